FILE: hdl/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg
// shared types and codes of the circular queue
// ----------------------------------------------------------------------------
package cq_pkg;

	localparam int DATA_W = 32;
	localparam int LEN_W  = 7;

	localparam logic [2:0] MODE_ENQ      = 3'd0;
	localparam logic [2:0] MODE_DEQ      = 3'd1;
	localparam logic [2:0] MODE_IS_EMPTY = 3'd2;
	localparam logic [2:0] MODE_IS_FULL  = 3'd3;
	localparam logic [2:0] MODE_TRAVERSE = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic                     answer;
		logic                     last;
	} rsp_t;

endpackage

FILE: hdl/circular_queue.sv
// ----------------------------------------------------------------------------
// circular_queue
// ring buffer of signed 32-bit values with a programmable length
// ----------------------------------------------------------------------------
// A request on req (valid/stall) carries a mode and a value; each request
// gives one response on rsp (valid/stall), except traverse, which gives one
// response per stored element, oldest first, with last set on the final one
// (one empty-status response on an empty queue). Modes outside the list are
// taken and give nothing. Slots sit in a single-port-read, single-port-write
// RAM with registered read data. A request is taken, the indices updated and
// the RAM read issued in the same cycle; the response register loads the read
// data once the output is free. A new request is taken in the cycle that the
// final response of the previous one is loaded, so enqueue, dequeue and
// queries sustain one per cycle while the response is not stalled.
// cfg (valid/ready, always ready) writes the queue length; write it only
// while no request is in flight. Zero acts as one, above DEPTH as DEPTH.
// Reset empties the queue and sets the length to 64; slot contents are not
// cleared. A stalled response holds its register; a request can still be
// taken while idle, but no further response is loaded until it moves.
// ----------------------------------------------------------------------------
module circular_queue #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  cq_pkg::req_t              req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output cq_pkg::rsp_t              rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cq_pkg::LEN_W-1:0]  cfg_data
);
	import cq_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW0  = $clog2(DEPTH + 1);
	localparam int LW   = (CW0 > LEN_W) ? CW0 : LEN_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic              state_q;
	logic [LEN_W-1:0]  len_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic              empty_q;

	logic [1:0]        status_q;
	logic              answer_q;
	logic              use_rd_q;
	logic              trav_q;
	logic [AW-1:0]     idx_q;
	logic [LW-1:0]     cnt_q;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [LW-1:0]     len_ext;
	logic [LW-1:0]     eff_len;
	logic [AW-1:0]     tail_step;
	logic [AW-1:0]     head_step;
	logic [AW-1:0]     idx_step;
	logic              full;
	logic              go;
	logic              out_free;
	logic              end_now;
	logic              done;
	logic              valid_mode;

	logic              we;
	logic [AW-1:0]     waddr;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;

	function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] i,
		input logic [LW-1:0] len);
		logic [LW-1:0] n;
		begin
			n = LW'(i) + LW'(1);
			step_idx = (n >= len) ? '0 : n[AW-1:0];
		end
	endfunction

	always_comb begin
		len_ext = LW'(len_q);
		if (len_ext == '0) begin
			eff_len = LW'(1);
		end else if (len_ext > DEPTH_L) begin
			eff_len = DEPTH_L;
		end else begin
			eff_len = len_ext;
		end
	end

	assign tail_step = step_idx(tail_q, eff_len);
	assign head_step = step_idx(head_q, eff_len);
	assign idx_step  = step_idx(idx_q, eff_len);
	assign full      = !empty_q && (tail_step == head_q);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign end_now   = !trav_q || (idx_q == tail_q) || ((cnt_q + LW'(1)) >= eff_len);
	assign done      = (state_q == S_EMIT) && out_free && end_now;
	assign req_stall = !((state_q == S_IDLE) || done);
	assign go        = req_valid && !req_stall;
	assign valid_mode = (req.mode == MODE_ENQ) || (req.mode == MODE_DEQ) ||
		(req.mode == MODE_IS_EMPTY) || (req.mode == MODE_IS_FULL) ||
		(req.mode == MODE_TRAVERSE);

	// ram control
	always_comb begin
		we    = 1'b0;
		waddr = empty_q ? '0 : tail_step;
		re    = 1'b0;
		raddr = head_q;
		if (go) begin
			case (req.mode)
				MODE_ENQ: we = !full;
				MODE_DEQ, MODE_TRAVERSE: re = !empty_q;
				default: ;
			endcase
		end else if (state_q == S_EMIT && out_free && !end_now) begin
			re    = 1'b1;
			raddr = idx_step;
		end
	end

	cq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req.value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	// queue state and request sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			empty_q  <= 1'b1;
			trav_q   <= 1'b0;
			use_rd_q <= 1'b0;
			status_q <= STATUS_OK;
			answer_q <= 1'b0;
			idx_q    <= '0;
			cnt_q    <= '0;
		end else if (go) begin
			state_q  <= valid_mode ? S_EMIT : S_IDLE;
			status_q <= STATUS_OK;
			answer_q <= 1'b0;
			use_rd_q <= 1'b0;
			trav_q   <= 1'b0;
			idx_q    <= head_q;
			cnt_q    <= '0;
			case (req.mode)
				MODE_ENQ: begin
					if (full) begin
						status_q <= STATUS_FULL;
					end else if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else begin
						tail_q <= tail_step;
					end
				end
				MODE_DEQ: begin
					if (empty_q) begin
						status_q <= STATUS_EMPTY;
					end else begin
						use_rd_q <= 1'b1;
						if (head_q == tail_q) begin
							empty_q <= 1'b1;
							head_q  <= '0;
							tail_q  <= '0;
						end else begin
							head_q <= head_step;
						end
					end
				end
				MODE_IS_EMPTY: answer_q <= empty_q;
				MODE_IS_FULL:  answer_q <= full;
				MODE_TRAVERSE: begin
					if (empty_q) begin
						status_q <= STATUS_EMPTY;
					end else begin
						use_rd_q <= 1'b1;
						trav_q   <= 1'b1;
					end
				end
				default: ;
			endcase
		end else if (done) begin
			state_q <= S_IDLE;
			trav_q  <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			idx_q <= idx_step;
			cnt_q <= cnt_q + LW'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			rsp_q.status <= status_q;
			rsp_q.data   <= use_rd_q ? rdata : '0;
			rsp_q.answer <= answer_q;
			rsp_q.last   <= end_now;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hdl/cq_ram.sv
// ----------------------------------------------------------------------------
// cq_ram
// slot storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module cq_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [cq_pkg::DATA_W-1:0]   wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [cq_pkg::DATA_W-1:0]   rdata
);
	import cq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking regression of the circular queue
// ----------------------------------------------------------------------------
// A directed table opens the run. It covers the empty and full answers, the
// value extremes, every mode including the unused ones, and a length change on
// a queue that is in use. The table also sets out-of-range lengths (zero and
// above the depth). Random requests follow under several lengths and three
// idle profiles. Every response is checked field by field against the table's
// expected value or a behavioural copy of the ring buffer. Lengths are only
// changed while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
	import cq_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [2:0] MODE_UNUSED_5 = 3'd5;
	localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
	localparam int SETTLE_CYCLES = 4;
	localparam int ITEMS_PER_BLOCK = 38;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  mode;
		logic [31:0] value;
		bit          typed;
		rsp_t        want;
	} stim_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	logic [DATA_W-1:0] slot_mem [DEPTH];
	logic [5:0]        head_idx;
	logic [5:0]        tail_idx;
	bit                q_empty;
	logic [LEN_W-1:0]  queue_len;

	rsp_t      expected_rsp [$];
	rsp_t      op_rsp [$];
	stim_row_t table_rows [$];
	int        errors = 0;
	int        send_idle_pct = 0;
	int        rcv_idle_pct = 0;

	circular_queue #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(64'd4_000_000);
		$display("circular_queue regression: fail");
		$finish;
	end

	function automatic rsp_t make_rsp(logic [1:0] status, logic [31:0] data, logic answer,
			logic last);
		rsp_t r;
		r.status = status;
		r.data   = data;
		r.answer = answer;
		r.last   = last;
		return r;
	endfunction

	function automatic int active_len();
		if (queue_len == 0)
			return 1;
		if (queue_len > DEPTH)
			return DEPTH;
		return int'(queue_len);
	endfunction

	function automatic logic [5:0] next_idx(logic [5:0] i);
		int n;
		n = int'(i) + 1;
		return (n >= active_len()) ? 6'd0 : n[5:0];
	endfunction

	function automatic bit ring_full();
		return !q_empty && next_idx(tail_idx) == head_idx;
	endfunction

	// ring buffer behaviour, results left in op_rsp
	function automatic void apply_queue_op(logic [2:0] mode, logic [31:0] value);
		logic [5:0] idx;
		int         count;
		bit         stop;
		op_rsp.delete();
		case (mode)
			MODE_ENQ: begin
				if (ring_full()) begin
					op_rsp.push_back(make_rsp(STATUS_FULL, '0, 1'b0, 1'b1));
				end else begin
					if (q_empty) begin
						head_idx = '0;
						tail_idx = '0;
						q_empty  = 1'b0;
					end else begin
						tail_idx = next_idx(tail_idx);
					end
					slot_mem[tail_idx] = value;
					op_rsp.push_back(make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
				end
			end
			MODE_DEQ: begin
				if (q_empty) begin
					op_rsp.push_back(make_rsp(STATUS_EMPTY, '0, 1'b0, 1'b1));
				end else begin
					op_rsp.push_back(make_rsp(STATUS_OK, slot_mem[head_idx], 1'b0, 1'b1));
					if (head_idx == tail_idx) begin
						q_empty  = 1'b1;
						head_idx = '0;
						tail_idx = '0;
					end else begin
						head_idx = next_idx(head_idx);
					end
				end
			end
			MODE_IS_EMPTY: op_rsp.push_back(make_rsp(STATUS_OK, '0, q_empty, 1'b1));
			MODE_IS_FULL:  op_rsp.push_back(make_rsp(STATUS_OK, '0, ring_full(), 1'b1));
			MODE_TRAVERSE: begin
				if (q_empty) begin
					op_rsp.push_back(make_rsp(STATUS_EMPTY, '0, 1'b0, 1'b1));
				end else begin
					idx   = head_idx;
					count = 0;
					do begin
						stop = (idx == tail_idx) || (count + 1 >= active_len());
						op_rsp.push_back(make_rsp(STATUS_OK, slot_mem[idx], 1'b0, stop));
						count++;
						idx = next_idx(idx);
					end while (!stop);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected response", rsp.data, '0);
				end else begin
					if (rsp.status !== expected_rsp[0].status)
						report_mismatch("status", 32'(rsp.status),
							32'(expected_rsp[0].status));
					if (rsp.data !== expected_rsp[0].data)
						report_mismatch("data", rsp.data, expected_rsp[0].data);
					if (rsp.answer !== expected_rsp[0].answer)
						report_mismatch("answer", 32'(rsp.answer),
							32'(expected_rsp[0].answer));
					if (rsp.last !== expected_rsp[0].last)
						report_mismatch("last", 32'(rsp.last), 32'(expected_rsp[0].last));
					void'(expected_rsp.pop_front());
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	task automatic send_request(logic [2:0] mode, logic [31:0] value, bit typed, rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req.mode   <= mode;
		req.value  <= value;
		do @(posedge clk); while (req_stall);
		apply_queue_op(mode, value);
		if (typed)
			expected_rsp.push_back(want);
		else
			foreach (op_rsp[i]) expected_rsp.push_back(op_rsp[i]);
	endtask

	// hold off until every response is back and the block has gone quiet
	task automatic settle();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(logic [LEN_W-1:0] len);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		queue_len = len;
	endtask

	task automatic drain_queue();
		while (!q_empty) send_request(MODE_DEQ, $urandom, 1'b0, '0);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_mode(int enq_pct);
		int r;
		if ($urandom_range(99) < enq_pct)
			return MODE_ENQ;
		r = $urandom_range(99);
		if (r < 50)
			return MODE_DEQ;
		if (r < 62)
			return MODE_IS_EMPTY;
		if (r < 74)
			return MODE_IS_FULL;
		if (r < 94)
			return MODE_TRAVERSE;
		case ($urandom_range(2))
			0: return MODE_UNUSED_5;
			1: return MODE_UNUSED_6;
			default: return MODE_UNUSED_7;
		endcase
	endfunction

	function automatic void add_row(row_kind_t kind, logic [2:0] mode, logic [31:0] value,
			bit typed, rsp_t want);
		stim_row_t row;
		row.kind  = kind;
		row.mode  = mode;
		row.value = value;
		row.typed = typed;
		row.want  = want;
		table_rows.push_back(row);
	endfunction

	initial begin
		int len_sel;
		int enq_pct;
		logic [LEN_W-1:0] len;

		foreach (slot_mem[i]) slot_mem[i] = '0;
		head_idx  = '0;
		tail_idx  = '0;
		q_empty   = 1'b1;
		queue_len = LEN_RESET;

		// after reset, extremes, unused modes, then a length cut on a live queue
		add_row(ROW_REQ, MODE_IS_EMPTY, '0, 1, make_rsp(STATUS_OK, '0, 1'b1, 1'b1));
		add_row(ROW_REQ, MODE_DEQ, '0, 1, make_rsp(STATUS_EMPTY, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_TRAVERSE, '0, 1, make_rsp(STATUS_EMPTY, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_IS_FULL, '0, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_ENQ, 32'h7fff_ffff, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_ENQ, 32'h8000_0000, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_ENQ, 32'h0000_0000, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_ENQ, 32'hffff_ffff, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_ENQ, 32'h0000_0001, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_TRAVERSE, '0, 0, '0);
		add_row(ROW_REQ, MODE_UNUSED_5, 32'h1234_5678, 0, '0);
		add_row(ROW_REQ, MODE_UNUSED_6, 32'hffff_ffff, 0, '0);
		add_row(ROW_REQ, MODE_UNUSED_7, '0, 0, '0);
		add_row(ROW_CFG, '0, 32'd3, 0, '0);
		add_row(ROW_REQ, MODE_IS_FULL, '0, 0, '0);
		add_row(ROW_REQ, MODE_ENQ, 32'd123, 0, '0);
		add_row(ROW_REQ, MODE_TRAVERSE, '0, 0, '0);
		add_row(ROW_REQ, MODE_DEQ, '0, 0, '0);
		add_row(ROW_REQ, MODE_ENQ, 32'd55, 0, '0);
		add_row(ROW_REQ, MODE_DEQ, '0, 0, '0);
		add_row(ROW_REQ, MODE_DEQ, '0, 0, '0);
		add_row(ROW_REQ, MODE_DEQ, '0, 0, '0);
		add_row(ROW_CFG, '0, 32'd0, 0, '0);
		add_row(ROW_REQ, MODE_ENQ, 32'hffff_fffb, 1, make_rsp(STATUS_OK, '0, 1'b0, 1'b1));
		add_row(ROW_REQ, MODE_IS_FULL, '0, 0, '0);
		add_row(ROW_REQ, MODE_ENQ, 32'd9, 0, '0);
		add_row(ROW_REQ, MODE_DEQ, '0, 0, '0);
		add_row(ROW_CFG, '0, 32'd127, 0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 18;
		rcv_idle_pct  = 67;
		foreach (table_rows[i]) begin
			if (table_rows[i].kind == ROW_CFG)
				write_length(table_rows[i].value[LEN_W-1:0]);
			else
				send_request(table_rows[i].mode, table_rows[i].value, table_rows[i].typed,
					table_rows[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 67 : 0;
			rcv_idle_pct  = (phase == 0) ? 67 : (phase == 1) ? 18 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				drain_queue();
				len_sel = (blk == 0) ? $urandom_range(1, 4) :
					(blk == 1) ? $urandom_range(5, 16) :
					(phase == 1) ? DEPTH : $urandom_range(17, 127);
				len = len_sel[LEN_W-1:0];
				write_length(len);
				enq_pct = $urandom_range(30, 65);
				for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
					if ($urandom_range(39) == 0)
						settle();
					send_request(pick_mode(enq_pct), pick_value(), 1'b0, '0);
				end
			end
		end

		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("circular_queue regression: pass");
		else
			$display("circular_queue regression: fail");
		$finish;
	end

endmodule
